[src/stereo_soft_noise_gate_core_assert.svh]
// Assertion macros for the checker file of the noise gate.
// Clock and reset are taken from the scope of the checker: clk, rst.
`ifndef STEREO_SOFT_NOISE_GATE_CORE_ASSERT_SVH
`define STEREO_SOFT_NOISE_GATE_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SSNG_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("noise gate check failed: %m");

// next-cycle implication, off during reset
`define SSNG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("noise gate check failed: %m");

// next-cycle implication that also holds across reset
`define SSNG_ASSERT_RST(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("noise gate check failed: %m");

`endif

[src/ssng_pkg.sv]
// Shared types and constants of the stereo soft noise gate.
// Frame structs, register codes and microcode word layout; no dependencies.
package ssng_pkg;

  localparam int SAMPLE_WIDTH       = 24;
  localparam int SAMPLE_FRAC        = SAMPLE_WIDTH - 1;
  localparam int GATE_FRAC_BITS_DEF = 22;
  localparam int RATIO_WIDTH        = 32;
  localparam int CFG_ADDR_WIDTH     = 4;
  localparam int CFG_DATA_WIDTH     = 32;
  localparam int UPC_W              = 5;

  localparam logic [SAMPLE_WIDTH-1:0] ONE_S = {1'b1, {SAMPLE_FRAC{1'b0}}};

  localparam logic [SAMPLE_WIDTH-1:0] THRESHOLD_RST = SAMPLE_WIDTH'(131072);
  localparam logic [SAMPLE_WIDTH-1:0] RECOVERY_RST  = SAMPLE_WIDTH'(32);
  localparam logic [SAMPLE_WIDTH-1:0] BASELINE_RST  = SAMPLE_WIDTH'(0);
  localparam logic [RATIO_WIDTH-1:0]  RATIO_RST     = RATIO_WIDTH'(16);

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_RECOVERY  = 2'd1,
    REG_BASELINE  = 2'd2,
    REG_RATIO     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_sample;
    logic signed [SAMPLE_WIDTH-1:0] right_sample;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] left_out;
    logic signed [SAMPLE_WIDTH-1:0] right_out;
  } out_frame_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_t;

  // multiplier operand A
  typedef enum logic [3:0] {
    OPA_GDIFF = 4'd0,   // gate - baseline
    OPA_GATE  = 4'd1,
    OPA_MAGL  = 4'd2,
    OPA_MAGR  = 4'd3,
    OPA_DL    = 4'd4,
    OPA_DR    = 4'd5,
    OPA_XL    = 4'd6,
    OPA_XR    = 4'd7,
    OPA_SL    = 4'd8,
    OPA_SR    = 4'd9
  } opa_t;

  // multiplier operand B
  typedef enum logic [1:0] {
    OPB_INV   = 2'd0,   // 1 - recovery
    OPB_RATIO = 2'd1,
    OPB_GATE  = 2'd2,
    OPB_CGATE = 2'd3    // 1 - gate
  } opb_t;

  typedef enum logic [3:0] {
    WB_NONE       = 4'd0,
    WB_TRIG       = 4'd1,
    WB_DECAY      = 4'd2,
    WB_ACC_R23    = 4'd3,
    WB_ACC_RREC   = 4'd4,
    WB_GATE_CLAMP = 4'd5,
    WB_GATE_OPEN  = 4'd6,
    WB_SL         = 4'd7,
    WB_SR         = 4'd8,
    WB_ACC_LOAD   = 4'd9,
    WB_ACC_ADD    = 4'd10,
    WB_RES_L_LOAD = 4'd11,
    WB_RES_R      = 4'd12,
    WB_PASS       = 4'd13
  } wb_op_t;

  typedef enum logic [1:0] {
    JMP_NEVER  = 2'd0,
    JMP_ALWAYS = 2'd1,
    JMP_TRIG   = 2'd2,
    JMP_OPEN   = 2'd3   // gate at or above one
  } jmp_t;

  typedef struct packed {
    opa_t             opa;
    opb_t             opb;
    wb_op_t           wb;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
    logic             done;
  } uword_t;

endpackage

[src/stereo_soft_noise_gate_core.sv]
// Stereo soft noise gate: microcoded sequencer around one shared multiplier.
// Depends on ssng_pkg for frame structs, register codes and microcode types.
//
// Usage:
//  - Input channel in_valid/in_stall/in_data carries one stereo frame per
//    transaction; output channel out_valid/out_stall/out_data returns one
//    gated frame per input frame, in order.
//  - Registers are written over the APB port (threshold at 0x0, recovery 0x4,
//    baseline 0x8, recovery_ratio 0xC) while the block is idle.
//  - A frame runs through a microcode program of 6 to 17 steps, one product
//    of the shared multiplier per step: 6 when a step reopens the gate, 10
//    when the gate ends at or above one, 17 when the blend path runs. The
//    result is registered at the edge that ends the last step, and the next
//    frame is taken the cycle after that.
//  - A finished result waits in the output register; a new frame is taken
//    meanwhile, and its program holds on its last step while out_stall keeps
//    the earlier result in place.
//  - Synchronous reset restores the registers to their defaults, the gate to
//    1.1 and both smoothed samples to zero, and empties the output.
module stereo_soft_noise_gate_core
  import ssng_pkg::*;
#(
  parameter int GATE_FRAC_BITS = GATE_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_frame_t                 in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_frame_t                out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int SF  = SAMPLE_FRAC;
  localparam int G   = GATE_FRAC_BITS;
  localparam int GW  = G + 2;
  localparam int AW  = (G + 3 > SW + 1) ? G + 3 : SW + 1;
  localparam int BW  = (G + 2 > RATIO_WIDTH + 1) ? G + 2 : RATIO_WIDTH + 1;
  localparam int PW  = AW + BW;
  localparam int ACW = PW + 1;

  localparam int REC_SH = SF + 16 - G;
  localparam int BSH_L  = (G >= SF) ? G - SF : 0;
  localparam int BSH_R  = (G < SF) ? SF - G : 0;
  localparam int BS_HALF = (BSH_R > 0) ? (1 << (BSH_R - 1)) : 0;

  localparam logic [GW-1:0] ONE_G    = {2'b01, {G{1'b0}}};
  localparam logic [GW-1:0] GATE_MAX = {GW{1'b1}};
  localparam longint unsigned OPEN_L = ((64'd11 << G) + 64'd5) / 64'd10;
  localparam logic [GW-1:0] GATE_OPEN = GW'(OPEN_L);

  localparam logic signed [ACW-1:0] HALF_SF  = ACW'(64'd1 << (SF - 1));
  localparam logic signed [ACW-1:0] HALF_REC = ACW'(64'd1 << (REC_SH - 1));
  localparam logic signed [ACW-1:0] HALF_G   = ACW'(64'd1 << (G - 1));
  localparam logic signed [ACW-1:0] SAT_HI   = ACW'({1'b0, {SF{1'b1}}});
  localparam logic signed [ACW-1:0] SAT_LO   = -ACW'({1'b1, {SF{1'b0}}});
  localparam logic signed [ACW-1:0] GMAX_X   = ACW'({1'b0, GATE_MAX});

  // microcode addresses
  localparam logic [UPC_W-1:0] U_DIFF   = UPC_W'(0);
  localparam logic [UPC_W-1:0] U_DECAY  = UPC_W'(1);
  localparam logic [UPC_W-1:0] U_MGATE  = UPC_W'(2);
  localparam logic [UPC_W-1:0] U_MRECL  = UPC_W'(3);
  localparam logic [UPC_W-1:0] U_MRECR  = UPC_W'(4);
  localparam logic [UPC_W-1:0] U_ADDR   = UPC_W'(5);
  localparam logic [UPC_W-1:0] U_CLAMP  = UPC_W'(6);
  localparam logic [UPC_W-1:0] U_OPEN   = UPC_W'(7);
  localparam logic [UPC_W-1:0] U_CHECK  = UPC_W'(8);
  localparam logic [UPC_W-1:0] U_MDL    = UPC_W'(9);
  localparam logic [UPC_W-1:0] U_MDR    = UPC_W'(10);
  localparam logic [UPC_W-1:0] U_MXL    = UPC_W'(11);
  localparam logic [UPC_W-1:0] U_MSL    = UPC_W'(12);
  localparam logic [UPC_W-1:0] U_MXR    = UPC_W'(13);
  localparam logic [UPC_W-1:0] U_MSR    = UPC_W'(14);
  localparam logic [UPC_W-1:0] U_SUMR   = UPC_W'(15);
  localparam logic [UPC_W-1:0] U_RESR   = UPC_W'(16);
  localparam logic [UPC_W-1:0] U_PASS   = UPC_W'(17);
  localparam logic [UPC_W-1:0] U_DONE   = UPC_W'(18);

  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    w = '{opa: OPA_GATE, opb: OPB_INV, wb: WB_NONE, jmp: JMP_NEVER,
          target: U_DONE, done: 1'b0};
    unique case (addr)
      U_DIFF:  begin w.opa = OPA_GDIFF; w.wb = WB_TRIG; end
      U_DECAY: begin w.wb = WB_DECAY; w.jmp = JMP_TRIG; w.target = U_OPEN; end
      U_MGATE: begin w.opa = OPA_GATE; w.opb = OPB_INV; end
      U_MRECL: begin w.opa = OPA_MAGL; w.opb = OPB_RATIO; w.wb = WB_ACC_R23; end
      U_MRECR: begin w.opa = OPA_MAGR; w.opb = OPB_RATIO; w.wb = WB_ACC_RREC; end
      U_ADDR:  w.wb = WB_ACC_RREC;
      U_CLAMP: begin
        w.wb = WB_GATE_CLAMP; w.jmp = JMP_ALWAYS; w.target = U_CHECK;
      end
      U_OPEN:  w.wb = WB_GATE_OPEN;
      U_CHECK: begin w.jmp = JMP_OPEN; w.target = U_PASS; end
      U_MDL:   begin w.opa = OPA_DL; w.opb = OPB_GATE; end
      U_MDR:   begin w.opa = OPA_DR; w.opb = OPB_GATE; w.wb = WB_SL; end
      U_MXL:   begin w.opa = OPA_XL; w.opb = OPB_GATE; w.wb = WB_SR; end
      U_MSL:   begin w.opa = OPA_SL; w.opb = OPB_CGATE; w.wb = WB_ACC_LOAD; end
      U_MXR:   begin w.opa = OPA_XR; w.opb = OPB_GATE; w.wb = WB_ACC_ADD; end
      U_MSR:   begin w.opa = OPA_SR; w.opb = OPB_CGATE; w.wb = WB_RES_L_LOAD; end
      U_SUMR:  w.wb = WB_ACC_ADD;
      U_RESR:  begin w.wb = WB_RES_R; w.jmp = JMP_ALWAYS; w.target = U_DONE; end
      U_PASS:  w.wb = WB_PASS;
      U_DONE:  w.done = 1'b1;
      default: w.done = 1'b1;
    endcase
    return w;
  endfunction

  function automatic logic signed [SW-1:0] sat_s(input logic signed [ACW-1:0] v);
    logic signed [ACW-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    else if (v < SAT_LO) c = SAT_LO;
    return SW'(c);
  endfunction

  // configuration
  logic [SW-1:0]          threshold;
  logic [SW-1:0]          recovery;
  logic [SW-1:0]          baseline;
  logic [RATIO_WIDTH-1:0] recovery_ratio;

  // state and datapath
  seq_state_t              state;
  logic [UPC_W-1:0]        pc;
  logic [GW-1:0]           gate_level;
  logic signed [SW-1:0]    xl, xr, sl, sr, res_l, res_r;
  logic                    trig;
  logic signed [PW-1:0]    prod;
  logic signed [ACW-1:0]   acc;

  uword_t                  uw;
  logic [SW-1:0]           rec, bs, inv;
  logic [SW:0]             bs_rnd;
  logic [GW-1:0]           base_g;
  logic signed [SW:0]      dl, dr;
  logic [SW:0]             mag_dl, mag_dr;
  logic [SW-1:0]           mag_xl, mag_xr;
  logic signed [AW-1:0]    opa;
  logic signed [BW-1:0]    opb;
  logic signed [PW-1:0]    mul_res;
  logic signed [ACW-1:0]   prod_x, r_sf, r_rec, r_g, acc_rg;
  logic                    take_jump;
  logic                    out_free;
  logic                    out_load;

  assign uw = ucode(pc);

  assign rec    = (recovery > ONE_S) ? ONE_S : recovery;
  assign bs     = (baseline > ONE_S) ? ONE_S : baseline;
  assign inv    = ONE_S - rec;
  assign bs_rnd = {1'b0, bs} + (SW + 1)'(BS_HALF);
  assign base_g = (G >= SF) ? (GW'(bs) << BSH_L) : GW'(bs_rnd >> BSH_R);

  assign dl     = (SW + 1)'(xl) - (SW + 1)'(sl);
  assign dr     = (SW + 1)'(xr) - (SW + 1)'(sr);
  assign mag_dl = dl[SW] ? $unsigned(-dl) : $unsigned(dl);
  assign mag_dr = dr[SW] ? $unsigned(-dr) : $unsigned(dr);
  assign mag_xl = xl[SW-1] ? $unsigned(-xl) : $unsigned(xl);
  assign mag_xr = xr[SW-1] ? $unsigned(-xr) : $unsigned(xr);

  always_comb begin
    unique case (uw.opa)
      OPA_GDIFF: opa = AW'($signed({1'b0, gate_level})) - AW'($signed({1'b0, base_g}));
      OPA_GATE:  opa = AW'($signed({1'b0, gate_level}));
      OPA_MAGL:  opa = AW'($signed({1'b0, mag_xl}));
      OPA_MAGR:  opa = AW'($signed({1'b0, mag_xr}));
      OPA_DL:    opa = AW'(dl);
      OPA_DR:    opa = AW'(dr);
      OPA_XL:    opa = AW'(xl);
      OPA_XR:    opa = AW'(xr);
      OPA_SL:    opa = AW'(sl);
      OPA_SR:    opa = AW'(sr);
      default:   opa = '0;
    endcase
  end

  always_comb begin
    unique case (uw.opb)
      OPB_INV:   opb = BW'($signed({1'b0, inv}));
      OPB_RATIO: opb = BW'($signed({1'b0, recovery_ratio}));
      OPB_GATE:  opb = BW'($signed({1'b0, gate_level}));
      OPB_CGATE: opb = BW'($signed({1'b0, ONE_G - gate_level}));
      default:   opb = '0;
    endcase
  end

  assign mul_res = opa * opb;

  // round to nearest, ties up
  assign prod_x = ACW'(prod);
  assign r_sf   = (prod_x + HALF_SF) >>> SF;
  assign r_rec  = (prod_x + HALF_REC) >>> REC_SH;
  assign r_g    = (prod_x + HALF_G) >>> G;
  assign acc_rg = (acc + HALF_G) >>> G;

  always_comb begin
    unique case (uw.jmp)
      JMP_NEVER:  take_jump = 1'b0;
      JMP_ALWAYS: take_jump = 1'b1;
      JMP_TRIG:   take_jump = trig;
      JMP_OPEN:   take_jump = (gate_level >= ONE_G);
      default:    take_jump = 1'b0;
    endcase
  end

  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_RUN) && uw.done && out_free;
  assign in_stall = (state != ST_IDLE);
  assign pready   = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:2]))
      REG_THRESHOLD: prdata = CFG_DATA_WIDTH'(threshold);
      REG_RECOVERY:  prdata = CFG_DATA_WIDTH'(recovery);
      REG_BASELINE:  prdata = CFG_DATA_WIDTH'(baseline);
      REG_RATIO:     prdata = CFG_DATA_WIDTH'(recovery_ratio);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold      <= THRESHOLD_RST;
      recovery       <= RECOVERY_RST;
      baseline       <= BASELINE_RST;
      recovery_ratio <= RATIO_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:2]))
        REG_THRESHOLD: threshold      <= SW'(pwdata);
        REG_RECOVERY:  recovery       <= SW'(pwdata);
        REG_BASELINE:  baseline       <= SW'(pwdata);
        REG_RATIO:     recovery_ratio <= RATIO_WIDTH'(pwdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_res;
    if (rst) begin
      state      <= ST_IDLE;
      pc         <= U_DIFF;
      out_valid  <= 1'b0;
      gate_level <= GATE_OPEN;
      sl         <= '0;
      sr         <= '0;
    end else begin
      if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            xl    <= in_data.left_sample;
            xr    <= in_data.right_sample;
            pc    <= U_DIFF;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (uw.done) begin
            // hold here until the output register is free
            if (out_load) begin
              out_data.left_out  <= res_l;
              out_data.right_out <= res_r;
              out_valid          <= 1'b1;
              state              <= ST_IDLE;
            end
          end else begin
            pc <= take_jump ? uw.target : pc + UPC_W'(1);
          end
          unique case (uw.wb)
            WB_NONE: ;
            WB_TRIG: trig <= (mag_dl > {1'b0, threshold}) || (mag_dr > {1'b0, threshold});
            WB_DECAY: begin
              if (gate_level != '0) gate_level <= GW'(r_sf + ACW'({1'b0, base_g}));
            end
            WB_ACC_R23: acc <= r_sf;
            WB_ACC_RREC: begin
              if (threshold != '0) acc <= acc + r_rec;
            end
            WB_GATE_CLAMP: begin
              if (acc < 0) gate_level <= '0;
              else if (acc > GMAX_X) gate_level <= GATE_MAX;
              else gate_level <= GW'(acc);
            end
            WB_GATE_OPEN:  gate_level <= GATE_OPEN;
            WB_SL:         sl <= sat_s(ACW'(sl) + r_g);
            WB_SR:         sr <= sat_s(ACW'(sr) + r_g);
            WB_ACC_LOAD:   acc <= prod_x;
            WB_ACC_ADD:    acc <= acc + prod_x;
            WB_RES_L_LOAD: begin
              res_l <= sat_s(acc_rg);
              acc   <= prod_x;
            end
            WB_RES_R:      res_r <= sat_s(acc_rg);
            WB_PASS: begin
              sl    <= xl;
              sr    <= xr;
              res_l <= xl;
              res_r <= xr;
            end
            default: ;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/ssng_checker.sv]
// Port-level checks for the stereo soft noise gate, bound to the top level.
// Depends on ssng_pkg and the assertion macro header.
`include "stereo_soft_noise_gate_core_assert.svh"

module ssng_checker
  import ssng_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_frame_t out_data
);

  // an accepted transaction keeps the input side busy while it runs
  `SSNG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // a stalled result stays put
  `SSNG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // a result only appears after a frame was in work
  `SSNG_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(in_stall))

  `SSNG_ASSERT_RST(a_reset_empties, rst, !out_valid && !in_stall)

endmodule

bind stereo_soft_noise_gate_core ssng_checker u_ssng_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
